// File: rtl/adh_pkg.sv
`default_nettype none
package adh_pkg;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 104;
  localparam int CFG_IDX_W   = 4;
  localparam int COEF_W      = 16;
  localparam int OUT_CNT_W   = 24;
  localparam int TRIG_W      = 28;
  localparam int ANG_W       = 32;
  localparam int PROD_W      = COEF_W + TRIG_W;
  localparam int ACC_W       = PROD_W + 1;
  localparam int PIX_W       = 18;
  localparam int SIZE_W      = 13;
  localparam int NUM_COEFS   = 8;

  localparam logic signed [COEF_W-1:0] Q12_ONE = 16'sd4096;

  // angle constants in Q.24
  localparam logic [32:0]        TWO_PI_RED  = 33'd105414357;
  localparam logic [32:0]        RED_BIAS    = 33'd2213701497; // 21 turns
  localparam logic signed [27:0] TWO_PI_Q24  = 28'sd105414357;
  localparam logic [32:0]        PI_RED      = 33'd52707179;
  localparam logic signed [27:0] PI_Q24      = 28'sd52707179;
  localparam logic signed [27:0] HALF_PI_Q24 = 28'sd26353589;
  localparam logic signed [27:0] CORDIC_GAIN = 28'sd10188014;
  localparam logic [3:0]         ROT_LAST    = 4'd15;
  localparam logic [3:0]         RED_FIRST   = 4'd5;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_ITER  = 2'd1,
    MODE_READ  = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    COEF_A, COEF_B, COEF_C, COEF_D, COEF_E, COEF_F, COEF_G, COEF_H
  } coef_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_ANG, ST_TRIG_START, ST_TRIG_WAIT, ST_GAIN,
    ST_ACC, ST_RND, ST_PIX, ST_MRD, ST_MUPD, ST_OUT
  } top_state_t;

  typedef enum logic [2:0] {
    SC_IDLE, SC_RED, SC_WRAP, SC_FOLD, SC_ROT
  } sc_state_t;

  typedef struct packed {
    logic                    start;
    logic signed [ANG_W-1:0] angle;
  } sc_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [TRIG_W-1:0] sin_val;
    logic signed [TRIG_W-1:0] cos_val;
  } sc_rsp_t;

  typedef struct packed {
    logic             in_frame;
    logic [PIX_W-1:0] pos;
  } pix_t;

  function automatic logic signed [TRIG_W-1:0] atan_q24(input logic [3:0] i);
    logic signed [TRIG_W-1:0] v;
    unique case (i)
      4'd0:  v = 28'sd13176795;
      4'd1:  v = 28'sd7778716;
      4'd2:  v = 28'sd4110060;
      4'd3:  v = 28'sd2086331;
      4'd4:  v = 28'sd1047214;
      4'd5:  v = 28'sd524117;
      4'd6:  v = 28'sd262123;
      4'd7:  v = 28'sd131069;
      4'd8:  v = 28'sd65536;
      4'd9:  v = 28'sd32768;
      4'd10: v = 28'sd16384;
      4'd11: v = 28'sd8192;
      4'd12: v = 28'sd4096;
      4'd13: v = 28'sd2048;
      4'd14: v = 28'sd1024;
      default: v = 28'sd512;
    endcase
    return v;
  endfunction

  // round half away from zero of (v + 2.0) * size / 4.0
  function automatic pix_t to_pixel(input logic signed [COEF_W-1:0] v,
                                    input logic [SIZE_W-1:0] size);
    logic signed [16:0] off;
    logic signed [31:0] num;
    logic [31:0]        mag;
    logic [PIX_W-1:0]   q;
    pix_t               p;
    off = 17'(v) + 17'sd8192;
    num = 32'(off) * $signed({19'd0, size});
    mag = num[31] ? 32'(-num) : 32'(num);
    q = PIX_W'((mag + 32'd8192) >> 14);
    p.in_frame = (q == '0) || (!num[31] && (q < PIX_W'(size)));
    p.pos = num[31] ? '0 : q;
    return p;
  endfunction

endpackage
`default_nettype wire

// File: rtl/adh_sincos.sv
`default_nettype none
module adh_sincos (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire adh_pkg::sc_req_t req,
  output adh_pkg::sc_rsp_t      rsp
);
  import adh_pkg::*;

  sc_state_t state, state_next;
  logic [32:0] rem;
  logic signed [TRIG_W-1:0] r, x, y, z;
  logic neg_cos;
  logic [3:0] step;
  logic done;
  logic [32:0] sub;
  logic signed [TRIG_W-1:0] dx, dy, at;

  assign sub = TWO_PI_RED << step;
  assign dx  = y >>> step;
  assign dy  = x >>> step;
  assign at  = atan_q24(step);

  always_ff @(posedge clk) begin
    if (rst) state <= SC_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      SC_IDLE: if (req.start) state_next = SC_RED;
      SC_RED:  if (step == '0) state_next = SC_WRAP;
      SC_WRAP: state_next = SC_FOLD;
      SC_FOLD: state_next = SC_ROT;
      SC_ROT:  if (step == ROT_LAST) state_next = SC_IDLE;
      default: state_next = SC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == SC_ROT) && (step == ROT_LAST);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      SC_IDLE: begin
        // bias negative angles by whole turns so the reduction stays unsigned
        rem  <= req.angle[ANG_W-1] ? 33'(req.angle) + RED_BIAS : 33'(req.angle);
        step <= RED_FIRST;
      end
      SC_RED: begin
        if (rem >= sub) rem <= rem - sub;
        step <= step - 4'd1;
      end
      SC_WRAP: begin
        r <= (rem >= PI_RED) ? TRIG_W'(rem) - TWO_PI_Q24 : TRIG_W'(rem);
      end
      SC_FOLD: begin
        if (r > HALF_PI_Q24) begin
          z <= PI_Q24 - r;
          neg_cos <= 1'b1;
        end else if (r < -HALF_PI_Q24) begin
          z <= -PI_Q24 - r;
          neg_cos <= 1'b1;
        end else begin
          z <= r;
          neg_cos <= 1'b0;
        end
        x <= CORDIC_GAIN;
        y <= '0;
        step <= '0;
      end
      SC_ROT: begin
        if (!z[TRIG_W-1]) begin
          x <= x - dx;
          y <= y + dy;
          z <= z - at;
        end else begin
          x <= x + dx;
          y <= y - dy;
          z <= z + at;
        end
        step <= step + 4'd1;
      end
      default: ;
    endcase
  end

  assign rsp.done    = done;
  assign rsp.sin_val = y;
  assign rsp.cos_val = neg_cos ? -x : x;

endmodule
`default_nettype wire

// File: rtl/attractor_density_histogram_unit.sv
`default_nettype none
// Density histogram of a generalized de Jong attractor in Q4.12 fixed point.
// Each input transaction carries a mode: clear (zero every cell and the peak,
// restart at (1,1)), iterate once, or read one cell; each gives exactly one
// output transaction with the cell count, peak, hit pixel and current point.
// An iteration runs four sine/cosine evaluations in turn through one
// range-reduction plus 16-step CORDIC unit, and every angle and gain product
// through one 16x28 multiplier; each coordinate is then rounded, followed by
// pixel, memory and output steps. The next input is taken only once the
// previous result has left the output state, for reads as for iterations.
// Clearing sweeps the histogram memory one cell per cycle, all
// IMG_WIDTH*IMG_HEIGHT cells (65536 at default size), once after reset and on
// every clear; no input is taken during the sweep. A result that is still
// waiting on the output holds the next one in the output state.
// Coefficient writes are accepted every cycle but must only happen while the
// unit is idle.
module attractor_density_histogram_unit #(
  parameter int IMG_WIDTH  = 256,
  parameter int IMG_HEIGHT = 256,
  parameter int COUNT_BITS = 24
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // mode[1:0], read_col[9:2], read_row[17:10], zero pad
  input  wire logic [adh_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // cell_count[23:0], peak_count[47:24], hit_col[55:48], hit_row[63:56],
  // in_frame[64], point_x[80:65], point_y[96:81], zero pad
  output logic [adh_pkg::OUT_TDATA_W-1:0]           m_axis_tdata,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [adh_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [adh_pkg::COEF_W-1:0]           cfg_data
);
  import adh_pkg::*;

  localparam int DEPTH = IMG_WIDTH * IMG_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  top_state_t state, state_next;

  logic signed [COEF_W-1:0] coef [NUM_COEFS];
  logic signed [COEF_W-1:0] cur_x, cur_y, new_x, new_y;
  logic [COUNT_BITS-1:0] peak;
  logic [COUNT_BITS-1:0] hist_mem [DEPTH];
  logic [COUNT_BITS-1:0] rd_data;

  logic mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr, clr_addr, rd_addr_q, pix_addr;
  logic [COUNT_BITS-1:0] mem_wdata, cnt_inc;

  mode_t mode_q;
  logic rd_ok, clr_reply;
  logic [1:0] k;
  logic signed [COEF_W-1:0] mul_a;
  logic signed [TRIG_W-1:0] mul_b, trig;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0] acc, rsum;
  logic signed [ACC_W-25:0] rnd;
  logic signed [COEF_W-1:0] rnd_sat;
  logic [PIX_W-1:0] px_q, py_q;
  pix_t pix_x, pix_y;

  logic [COUNT_BITS-1:0] res_cell;
  logic [7:0] res_hc, res_hr;
  logic res_inf;

  logic [OUT_CNT_W-1:0] out_cell, out_peak;
  logic [7:0] out_hc, out_hr;
  logic out_inf;
  logic signed [COEF_W-1:0] out_x, out_y;
  logic out_free;

  sc_req_t sc_req;
  sc_rsp_t sc_rsp;

  adh_sincos u_sincos (
    .clk (clk),
    .rst (rst),
    .req (sc_req),
    .rsp (sc_rsp)
  );

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign m_axis_tdata = {7'd0, out_y, out_x, out_inf, out_hr, out_hc, out_peak, out_cell};

  // term k: 0 a*sin(b*y), 1 c*cos(d*x), 2 e*sin(f*x), 3 g*cos(h*y)
  always_comb begin
    mul_a = coef[{k, 1'b0}];
    mul_b = trig;
    if (state == ST_ANG) begin
      mul_a = coef[{k, 1'b1}];
      mul_b = TRIG_W'((k[0] ^ k[1]) ? cur_x : cur_y);
    end
  end

  assign sc_req.start = (state == ST_TRIG_START);
  assign sc_req.angle = prod[ANG_W-1:0];

  assign rsum = acc + ACC_W'(64'sd8388608);
  assign rnd  = rsum[ACC_W-1:24];
  always_comb begin
    if (rnd > 21'sd32767) rnd_sat = 16'sd32767;
    else if (rnd < -21'sd32768) rnd_sat = -16'sd32768;
    else rnd_sat = rnd[COEF_W-1:0];
  end

  assign pix_x    = to_pixel(new_x, SIZE_W'(IMG_WIDTH));
  assign pix_y    = to_pixel(new_y, SIZE_W'(IMG_HEIGHT));
  assign pix_addr = AW'(py_q * IMG_WIDTH + px_q);
  assign cnt_inc  = (rd_data == CNT_MAX) ? rd_data : rd_data + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = pix_addr;
    mem_wdata  = cnt_inc;
    mem_raddr  = (mode_q == MODE_ITER) ? pix_addr : rd_addr_q;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
        if (clr_addr == LAST_ADDR) state_next = clr_reply ? ST_OUT : ST_IDLE;
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          unique case (s_axis_tdata[1:0])
            MODE_CLEAR: state_next = ST_CLEAR;
            MODE_ITER:  state_next = ST_ANG;
            MODE_READ:  state_next = ST_MRD;
            default:    state_next = ST_OUT;
          endcase
        end
      end
      ST_ANG:        state_next = ST_TRIG_START;
      ST_TRIG_START: state_next = ST_TRIG_WAIT;
      ST_TRIG_WAIT:  if (sc_rsp.done) state_next = ST_GAIN;
      ST_GAIN:       state_next = ST_ACC;
      ST_ACC:        state_next = k[0] ? ST_RND : ST_ANG;
      ST_RND:        state_next = (k == 2'd3) ? ST_PIX : ST_ANG;
      ST_PIX:        state_next = ST_MRD;
      ST_MRD:        state_next = ST_MUPD;
      ST_MUPD: begin
        mem_we     = (mode_q == MODE_ITER) && res_inf;
        state_next = ST_OUT;
      end
      ST_OUT:        if (out_free) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) hist_mem[mem_waddr] <= mem_wdata;
    rd_data <= hist_mem[mem_raddr];
  end

  // shared multiplier, registered
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_COEFS; i++) coef[i] <= '0;
    end else if (cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(NUM_COEFS))) begin
      coef[cfg_index[2:0]] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x         <= Q12_ONE;
      cur_y         <= Q12_ONE;
      peak          <= '0;
      clr_addr      <= '0;
      clr_reply     <= 1'b0;
      m_axis_tvalid <= 1'b0;
      k             <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: clr_addr <= clr_addr + 1'b1;
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            k <= '0;
            if (s_axis_tdata[1:0] == MODE_CLEAR) begin
              cur_x     <= Q12_ONE;
              cur_y     <= Q12_ONE;
              peak      <= '0;
              clr_addr  <= '0;
              clr_reply <= 1'b1;
            end
          end
        end
        ST_ACC: if (!k[0]) k <= k + 2'd1;
        ST_RND: k <= k + 2'd1;
        ST_PIX: begin
          cur_x <= new_x;
          cur_y <= new_y;
        end
        ST_MUPD: begin
          if ((mode_q == MODE_ITER) && res_inf && (cnt_inc > peak)) peak <= cnt_inc;
        end
        default: ;
      endcase
      if (state == ST_OUT && out_free) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        mode_q    <= mode_t'(s_axis_tdata[1:0]);
        rd_addr_q <= AW'(32'(s_axis_tdata[17:10]) * IMG_WIDTH + 32'(s_axis_tdata[9:2]));
        rd_ok     <= (32'(s_axis_tdata[9:2]) < IMG_WIDTH) &&
                     (32'(s_axis_tdata[17:10]) < IMG_HEIGHT);
        res_cell  <= '0;
        res_hc    <= '0;
        res_hr    <= '0;
        res_inf   <= 1'b0;
      end
      ST_TRIG_WAIT: if (sc_rsp.done) trig <= k[0] ? sc_rsp.cos_val : sc_rsp.sin_val;
      ST_ACC: acc <= (k[0] ? acc : '0) + ACC_W'(prod);
      ST_RND: begin
        if (k == 2'd1) new_x <= rnd_sat;
        else new_y <= rnd_sat;
      end
      ST_PIX: begin
        px_q    <= pix_x.pos;
        py_q    <= pix_y.pos;
        res_inf <= pix_x.in_frame && pix_y.in_frame;
      end
      ST_MUPD: begin
        if (mode_q == MODE_ITER) begin
          if (res_inf) begin
            res_cell <= cnt_inc;
            res_hc   <= px_q[7:0];
            res_hr   <= py_q[7:0];
          end
        end else if (rd_ok) begin
          res_cell <= rd_data;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_cell <= OUT_CNT_W'(res_cell);
          out_peak <= OUT_CNT_W'(peak);
          out_hc   <= res_hc;
          out_hr   <= res_hr;
          out_inf  <= res_inf;
          out_x    <= cur_x;
          out_y    <= cur_y;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/adh_chk.sv
`default_nettype none
module adh_chk (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              s_axis_tvalid,
  input wire logic                              s_axis_tready,
  input wire logic [adh_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready,
  input wire logic [adh_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input wire logic                              cfg_valid,
  input wire logic                              cfg_ready,
  input wire logic [adh_pkg::CFG_IDX_W-1:0]     cfg_index,
  input wire logic [adh_pkg::COEF_W-1:0]        cfg_data
);

  logic unused;
  assign unused = ^{s_axis_tdata, cfg_valid, cfg_ready, cfg_index, cfg_data};

  a_idle_after_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  // one item at a time: busy right after an input transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input ready right after an accepted transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled output transaction changed");

  // an out-of-frame result carries no hit pixel
  a_miss_no_pixel: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tdata[64]) |-> (m_axis_tdata[63:48] == 16'd0))
    else $error("hit pixel set on out-of-frame result");

endmodule

bind attractor_density_histogram_unit adh_chk u_adh_chk (.*);
`default_nettype wire

// File: tb/adh_checker.sv
module adh_checker (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  input  wire logic                            s_axis_tready,
  input  wire logic [adh_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  wire logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  input  wire logic [adh_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  wire logic                            cfg_valid,
  input  wire logic                            cfg_ready,
  input  wire logic [adh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [adh_pkg::COEF_W-1:0]      cfg_data,
  output int                                   errors,
  output int                                   pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import adh_pkg::*;

  localparam longint TURN_Q24      = 105414357;
  localparam longint HALF_TURN_Q24 = 52707179;
  localparam longint QUARTER_Q24   = 26353589;
  localparam longint GAIN_Q24      = 10188014;
  localparam int     IMG_SIZE      = 256;
  localparam logic [23:0] CNT_MAX  = 24'hFFFFFF;
  localparam longint ATAN_Q24 [16] = '{13176795, 7778716, 4110060, 2086331, 1047214,
                                       524117, 262123, 131069, 65536, 32768, 16384,
                                       8192, 4096, 2048, 1024, 512};

  typedef struct {
    logic [23:0]        count;
    logic [23:0]        peak;
    logic [7:0]         col;
    logic [7:0]         row;
    logic               hit;
    logic signed [15:0] px;
    logic signed [15:0] py;
  } hist_result_t;

  logic [23:0]        density [0:65535];
  logic [23:0]        peak_cnt;
  logic signed [15:0] pt_x, pt_y;
  logic signed [15:0] coef [0:7];
  hist_result_t       result_q [$];

  function automatic void sin_cos(input longint ang, output longint s, output longint c);
    longint r, x, y, z, dx, dy;
    bit flip;
    r = ang % TURN_Q24;
    if (r < 0) r += TURN_Q24;
    if (r >= HALF_TURN_Q24) r -= TURN_Q24;
    flip = 0;
    if (r > QUARTER_Q24) begin
      r = HALF_TURN_Q24 - r;
      flip = 1;
    end else if (r < -QUARTER_Q24) begin
      r = -HALF_TURN_Q24 - r;
      flip = 1;
    end
    x = GAIN_Q24;
    y = 0;
    z = r;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_Q24[i];
      end else begin
        x += dx; y -= dy; z += ATAN_Q24[i];
      end
    end
    s = y;
    c = flip ? -x : x;
  endfunction

  // gs*sin(fs*p) + gc*cos(fc*q), rounded to Q4.12 and saturated
  function automatic logic signed [15:0] attractor_term(input longint gs, fs, p, gc, fc, q);
    longint s1, c1, s2, c2, sum;
    sin_cos(fs * p, s1, c1);
    sin_cos(fc * q, s2, c2);
    sum = (gs * s1 + gc * c2 + (64'sd1 <<< 23)) >>> 24;
    if (sum > 32767) sum = 32767;
    if (sum < -32768) sum = -32768;
    return 16'(sum);
  endfunction

  function automatic longint pixel_of(input longint v);
    longint num;
    num = (v + 8192) * IMG_SIZE;
    if (num >= 0) return (num + 8192) / 16384;
    return -((-num + 8192) / 16384);
  endfunction

  function automatic void wipe_density();
    for (int i = 0; i < 65536; i++) density[i] = '0;
    peak_cnt = '0;
    pt_x = Q12_ONE;
    pt_y = Q12_ONE;
  endfunction

  function automatic hist_result_t predict_step(input logic [IN_TDATA_W-1:0] d);
    hist_result_t r;
    logic signed [15:0] nx, ny;
    longint cx, cy;
    logic [7:0] col, row;
    col = d[9:2];
    row = d[17:10];
    r = '{default: '0};
    case (d[1:0])
      MODE_CLEAR: wipe_density();
      MODE_ITER: begin
        nx = attractor_term(coef[0], coef[1], pt_y, coef[2], coef[3], pt_x);
        ny = attractor_term(coef[4], coef[5], pt_x, coef[6], coef[7], pt_y);
        cx = pixel_of(nx);
        cy = pixel_of(ny);
        if (cx >= 0 && cx < IMG_SIZE && cy >= 0 && cy < IMG_SIZE) begin
          if (density[cy * IMG_SIZE + cx] != CNT_MAX)
            density[cy * IMG_SIZE + cx] = density[cy * IMG_SIZE + cx] + 1;
          r.count = density[cy * IMG_SIZE + cx];
          if (r.count > peak_cnt) peak_cnt = r.count;
          r.col = 8'(cx);
          r.row = 8'(cy);
          r.hit = 1'b1;
        end
        pt_x = nx;
        pt_y = ny;
      end
      MODE_READ: r.count = density[{row, col}];
      default: ;
    endcase
    r.peak = peak_cnt;
    r.px = pt_x;
    r.py = pt_y;
    return r;
  endfunction

  always @(posedge clk) begin
    hist_result_t e;
    if (rst) begin
      wipe_density();
      for (int i = 0; i < 8; i++) coef[i] = '0;
      result_q.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready && cfg_index < 8) coef[cfg_index[2:0]] = cfg_data;
      if (s_axis_tvalid && s_axis_tready) result_q.push_back(predict_step(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (result_q.size() == 0) begin
          $error("result transaction with nothing expected: %h", m_axis_tdata);
          errors++;
        end else begin
          e = result_q.pop_front();
          if (m_axis_tdata[23:0] !== e.count) begin
            $error("cell_count exp %0d got %0d", e.count, m_axis_tdata[23:0]); errors++;
          end
          if (m_axis_tdata[47:24] !== e.peak) begin
            $error("peak_count exp %0d got %0d", e.peak, m_axis_tdata[47:24]); errors++;
          end
          if (m_axis_tdata[55:48] !== e.col) begin
            $error("hit_col exp %0d got %0d", e.col, m_axis_tdata[55:48]); errors++;
          end
          if (m_axis_tdata[63:56] !== e.row) begin
            $error("hit_row exp %0d got %0d", e.row, m_axis_tdata[63:56]); errors++;
          end
          if (m_axis_tdata[64] !== e.hit) begin
            $error("in_frame exp %0d got %0d", e.hit, m_axis_tdata[64]); errors++;
          end
          if (m_axis_tdata[80:65] !== e.px) begin
            $error("point_x exp %0d got %0d", e.px, $signed(m_axis_tdata[80:65])); errors++;
          end
          if (m_axis_tdata[96:81] !== e.py) begin
            $error("point_y exp %0d got %0d", e.py, $signed(m_axis_tdata[96:81])); errors++;
          end
        end
      end
    end
    pending = result_q.size();
  end

endmodule

// File: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import adh_pkg::*;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst;
  logic s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COEF_W-1:0]    cfg_data;
  int errors, pending, cycles;
  bit stall_req;

  always #1 clk = ~clk;

  attractor_density_histogram_unit dut (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  adh_checker chk (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .errors, .pending
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // result side: own stall pattern, plus one long hold-off on request
  initial begin
    bit held;
    int n;
    held = 0;
    m_axis_tready <= 1'b0;
    forever begin
      if (stall_req && !held) begin
        held = 1;
        m_axis_tready <= 1'b0;
        repeat (3000) @(posedge clk);
      end else begin
        case ($urandom_range(2))
          0: begin
            n = $urandom_range(40, 1);
            m_axis_tready <= 1'b1;
            repeat (n) @(posedge clk);
          end
          1: repeat (20) begin
            m_axis_tready <= 1'($urandom_range(1));
            @(posedge clk);
          end
          default: begin
            n = $urandom_range(15, 1);
            m_axis_tready <= 1'b0;
            repeat (n) @(posedge clk);
          end
        endcase
      end
    end
  end

  task automatic send_item(input logic [1:0] m, input logic [7:0] col, input logic [7:0] row);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, row, col, m};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic pause_input(input int n);
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic write_coef(input int idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= 4'(coef_idx_t'(idx));
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    cfg_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_item();
    int r;
    logic [7:0] col, row;
    r = $urandom_range(99);
    if ($urandom_range(1)) begin
      col = 8'($urandom_range(255));
      row = 8'($urandom_range(255));
    end else begin
      col = 8'($urandom_range(136, 120));
      row = 8'($urandom_range(136, 120));
    end
    if (r < 3) send_item(MODE_SPARE, col, row);
    else if (r < 28) send_item(MODE_READ, col, row);
    else send_item(MODE_ITER, col, row);
  endtask

  task automatic random_run(input int count);
    int left, burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(8, 1);
      for (int i = 0; i < burst && left > 0; i++) begin
        random_item();
        left--;
      end
      if ($urandom_range(3) != 0) pause_input($urandom_range(6, 1));
    end
  endtask

  initial begin
    logic [15:0] classic [8];
    classic = '{16'(5734), 16'(-9421), 16'(9830), 16'(-8602),
                16'(7373), 16'(-7782), 16'(-3686), 16'(9011)};
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    cycles <= 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // zero coefficients: every iteration lands on the center pixel
    send_item(MODE_ITER, 8'd0, 8'd0);
    send_item(MODE_ITER, 8'd255, 8'd255);
    send_item(MODE_READ, 8'd128, 8'd128);
    send_item(MODE_READ, 8'd0, 8'd0);
    send_item(MODE_READ, 8'd255, 8'd255);
    send_item(MODE_READ, 8'd255, 8'd0);
    send_item(MODE_SPARE, 8'd255, 8'd255);
    send_item(MODE_SPARE, 8'd0, 8'd0);
    pause_input(3);
    send_item(MODE_ITER, 8'd128, 8'd128);
    send_item(MODE_READ, 8'd128, 8'd128);
    send_item(MODE_CLEAR, 8'd255, 8'd255);
    send_item(MODE_READ, 8'd128, 8'd128);
    send_item(MODE_ITER, 8'd0, 8'd255);
    send_item(MODE_READ, 8'd128, 8'd128);
    stall_req = 1'b1;
    random_run(40);
    drain();

    for (int p = 0; p < 5; p++) begin
      for (int i = 0; i < 8; i++) begin
        case (p)
          0: write_coef(i, classic[i]);
          1: write_coef(i, 16'h7FFF);
          2: write_coef(i, 16'h8000);
          default: write_coef(i, 16'($urandom));
        endcase
      end
      cfg_valid <= 1'b0;
      if (p % 2 == 1) send_item(MODE_CLEAR, 8'($urandom), 8'($urandom));
      random_run(200);
      drain();
    end

    repeat (150) @(posedge clk);
    if (errors == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule
